### sv/keyframe_preroll_ring_core_macros.svh
// ----------------------------------------------------------------------------
// keyframe_preroll_ring_core_macros.svh
// Assertion helpers for the keyframe pre-roll ring.
// ----------------------------------------------------------------------------
`ifndef KEYFRAME_PREROLL_RING_CORE_MACROS_SVH
`define KEYFRAME_PREROLL_RING_CORE_MACROS_SVH

// same-cycle implication, clocked on aclk, quiet during reset
`define KPR_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define KPR_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

`endif

### sv/kpr_pkg.sv
// ----------------------------------------------------------------------------
// kpr_pkg
// Shared types and codes of the keyframe pre-roll ring.
// ----------------------------------------------------------------------------
package kpr_pkg;

    localparam int MaxResults = 32;

    // func codes
    localparam logic [1:0] FN_PUSH   = 2'd0;
    localparam logic [1:0] FN_SELECT = 2'd1;
    localparam logic [1:0] FN_CLEAR  = 2'd2;

    // result status codes
    localparam logic [2:0] ST_ACCEPTED = 3'd0;
    localparam logic [2:0] ST_GEN_RST  = 3'd1;
    localparam logic [2:0] ST_TIME_RST = 3'd2;
    localparam logic [2:0] ST_INVALID  = 3'd3;
    localparam logic [2:0] ST_OVERSIZE = 3'd4;
    localparam logic [2:0] ST_CLEARED  = 3'd5;
    localparam logic [2:0] ST_SELECTED = 3'd6;
    localparam logic [2:0] ST_NONE     = 3'd7;

    // configuration register indexes
    localparam logic REG_RETENTION  = 1'b0;
    localparam logic REG_BYTE_LIMIT = 1'b1;

    typedef struct packed {
        logic [1:0]  func;
        logic [31:0] handle;
        logic [31:0] generation;
        logic [63:0] time_ns;
        logic [23:0] bytes;
        logic        keyframe;
        logic [63:0] trigger_ns;
        logic [63:0] preroll_ns;
    } in_item_t;

    // controller -> datapath
    typedef struct packed {
        logic       load_in;
        logic       req_load;
        logic       ring_reset;
        logic       append;
        logic       cut_load;
        logic       scan_init;
        logic       idx_clr;
        logic       idx_inc;
        logic       keep_set;
        logic       start_init;
        logic       start_set;
        logic       rd_head;
        logic       rd_scan;
        logic       rd_emit;
        logic       drop;
        logic       peak_upd;
        logic       emit;
        logic       emit_last;
        logic [2:0] emit_st;
    } cmd_t;

    // datapath -> controller
    typedef struct packed {
        logic [1:0] func;
        logic       invalid;
        logic       oversize;
        logic       gen_chg;
        logic       t_regr;
        logic       full;
        logic       cnt_nz;
        logic       cnt_gt1;
        logic       prune_skip;
        logic       bytes_over;
        logic       idx_lt_cnt;
        logic       idx_lt_keep;
        logic       found;
        logic       start_eq_cnt;
        logic       r_key;
        logic       r_gt_cut;
        logic       r_lt_cut;
        logic       r_gt_req;
        logic       r_gt_trig;
        logic       em_last;
        logic       out_free;
    } sts_t;

endpackage

### sv/kpr_dp.sv
// ----------------------------------------------------------------------------
// kpr_dp
// Ring datapath: descriptor store, ring pointers, statistics, output register.
// ----------------------------------------------------------------------------
module kpr_dp
    import kpr_pkg::*;
#(
    parameter int RING_DEPTH = 32
) (
    input  logic           aclk,
    input  logic           aresetn,
    input  logic           cfg_wr_en,
    input  logic           cfg_index,
    input  logic [63:0]    cfg_wdata,
    input  in_item_t       in_item,
    input  cmd_t           cmd,
    output sts_t           sts,
    input  logic           m_tready,
    output logic           m_tvalid,
    output logic [2:0]     m_tuser,
    output logic           m_tlast,
    output logic [359:0]   m_tdata
);

    localparam int AW = (RING_DEPTH > 1) ? $clog2(RING_DEPTH) : 1;
    localparam int CW = $clog2(RING_DEPTH + 1);

    typedef struct packed {
        logic [31:0] handle;
        logic [63:0] time_ns;
        logic [23:0] size;
        logic        key;
    } entry_t;

    entry_t          store_mem [RING_DEPTH];
    entry_t          rdata_reg;

    in_item_t        in_reg;
    logic [63:0]     ret_reg;
    logic [31:0]     limit_reg;
    logic [AW-1:0]   head_reg;
    logic [CW-1:0]   count_reg;
    logic [32:0]     bytes_reg;
    logic [31:0]     gen_reg;
    logic [63:0]     latest_reg;
    logic [31:0]     peak_reg;
    logic [31:0]     resets_reg;
    logic [63:0]     cut_reg;
    logic [63:0]     req_reg;
    logic [63:0]     act_reg;
    logic [CW-1:0]   idx_reg;
    logic [CW-1:0]   keep_reg;
    logic [CW-1:0]   start_reg;
    logic            found_reg;

    logic            out_valid_reg;
    logic [2:0]      out_st_reg;
    logic            out_last_reg;
    logic [358:0]    out_data_reg;

    function automatic logic [AW-1:0] slot_of(input logic [AW-1:0] base,
                                              input logic [CW-1:0] off);
        logic [CW:0] s;
        s = (CW+1)'(base) + (CW+1)'(off);
        if (s >= (CW+1)'(RING_DEPTH)) begin
            s = s - (CW+1)'(RING_DEPTH);
        end
        return AW'(s);
    endfunction

    logic [AW-1:0]   rd_addr;
    logic [AW-1:0]   wr_addr;
    logic [CW-1:0]   n_sel;
    logic            first;
    logic            is_sel;
    logic            is_none;
    logic [63:0]     act_v;
    logic [31:0]     o_handle;
    logic [63:0]     o_time;
    logic [63:0]     o_req;
    logic [63:0]     o_act;
    logic            o_comp;

    assign wr_addr = slot_of(head_reg, count_reg);

    always_comb begin
        rd_addr = head_reg;
        if (cmd.rd_scan) begin
            rd_addr = slot_of(head_reg, idx_reg);
        end else if (cmd.rd_emit) begin
            rd_addr = slot_of(head_reg, CW'(start_reg + idx_reg));
        end
    end

    // descriptor store, one write and one registered read port
    always_ff @(posedge aclk) begin
        if (cmd.append) begin
            store_mem[wr_addr] <= '{in_reg.handle, in_reg.time_ns, in_reg.bytes,
                                    in_reg.keyframe};
        end
        if (cmd.rd_head || cmd.rd_scan || cmd.rd_emit) begin
            rdata_reg <= store_mem[rd_addr];
        end
    end

    // status towards the controller
    assign n_sel = count_reg - start_reg;
    always_comb begin
        sts.func         = in_reg.func;
        sts.invalid      = (in_reg.bytes == '0) || (in_reg.generation == '0) ||
                           (in_reg.time_ns == '0);
        sts.oversize     = {8'd0, in_reg.bytes} > limit_reg;
        sts.gen_chg      = (count_reg != '0) && (in_reg.generation != gen_reg);
        sts.t_regr       = (count_reg != '0) && (in_reg.time_ns < latest_reg);
        sts.full         = count_reg >= CW'(RING_DEPTH);
        sts.cnt_nz       = count_reg != '0;
        sts.cnt_gt1      = count_reg > CW'(1);
        sts.prune_skip   = (count_reg < CW'(2)) || (latest_reg <= ret_reg);
        sts.bytes_over   = bytes_reg > {1'b0, limit_reg};
        sts.idx_lt_cnt   = idx_reg < count_reg;
        sts.idx_lt_keep  = idx_reg < keep_reg;
        sts.found        = found_reg;
        sts.start_eq_cnt = start_reg == count_reg;
        sts.r_key        = rdata_reg.key;
        sts.r_gt_cut     = rdata_reg.time_ns > cut_reg;
        sts.r_lt_cut     = rdata_reg.time_ns < cut_reg;
        sts.r_gt_req     = rdata_reg.time_ns > req_reg;
        sts.r_gt_trig    = rdata_reg.time_ns > in_reg.trigger_ns;
        sts.em_last      = (({1'b0, idx_reg} + (CW+1)'(1)) == {1'b0, n_sel}) ||
                           (32'(idx_reg) == 32'(MaxResults - 1));
        sts.out_free     = !out_valid_reg || m_tready;
    end

    // result fields
    always_comb begin
        first    = idx_reg == '0;
        is_sel   = cmd.emit_st == ST_SELECTED;
        is_none  = cmd.emit_st == ST_NONE;
        act_v    = first ? rdata_reg.time_ns : act_reg;
        o_handle = is_sel ? rdata_reg.handle : '0;
        o_time   = is_sel ? rdata_reg.time_ns : '0;
        o_req    = (is_sel || is_none) ? req_reg : '0;
        o_act    = is_sel ? act_v : '0;
        o_comp   = is_sel && (act_v <= req_reg);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            ret_reg       <= 64'd5000000000;
            limit_reg     <= 32'd16777216;
            head_reg      <= '0;
            count_reg     <= '0;
            bytes_reg     <= '0;
            gen_reg       <= '0;
            latest_reg    <= '0;
            peak_reg      <= '0;
            resets_reg    <= '0;
            out_valid_reg <= 1'b0;
        end else begin
            if (cfg_wr_en) begin
                if (cfg_index == REG_RETENTION) begin
                    ret_reg <= cfg_wdata;
                end else begin
                    limit_reg <= cfg_wdata[31:0];
                end
            end
            if (cmd.ring_reset) begin
                count_reg  <= '0;
                bytes_reg  <= '0;
                gen_reg    <= '0;
                latest_reg <= '0;
                resets_reg <= resets_reg + 32'd1;
            end
            if (cmd.append) begin
                count_reg  <= count_reg + CW'(1);
                bytes_reg  <= bytes_reg + 33'(in_reg.bytes);
                gen_reg    <= in_reg.generation;
                latest_reg <= in_reg.time_ns;
            end
            if (cmd.drop) begin
                bytes_reg <= bytes_reg - 33'(rdata_reg.size);
                head_reg  <= (head_reg == AW'(RING_DEPTH - 1)) ? '0 : head_reg + AW'(1);
                count_reg <= count_reg - CW'(1);
                if (count_reg == CW'(1)) begin
                    gen_reg    <= '0;
                    latest_reg <= '0;
                end
            end
            if (cmd.peak_upd && (bytes_reg > {1'b0, peak_reg})) begin
                peak_reg <= bytes_reg[31:0];
            end
            if (cmd.emit) begin
                out_valid_reg <= 1'b1;
            end else if (m_tready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // scan and working registers
    always_ff @(posedge aclk) begin
        if (cmd.load_in) begin
            in_reg <= in_item;
        end
        if (cmd.req_load) begin
            req_reg <= (in_reg.trigger_ns > in_reg.preroll_ns) ?
                       in_reg.trigger_ns - in_reg.preroll_ns : '0;
        end
        if (cmd.cut_load) begin
            cut_reg <= latest_reg - ret_reg;
        end
        if (cmd.scan_init) begin
            idx_reg   <= '0;
            found_reg <= 1'b0;
        end else if (cmd.idx_clr) begin
            idx_reg <= '0;
        end else if (cmd.idx_inc) begin
            idx_reg <= idx_reg + CW'(1);
        end
        if (cmd.keep_set) begin
            keep_reg  <= idx_reg;
            found_reg <= 1'b1;
        end
        if (cmd.start_init) begin
            start_reg <= count_reg;
        end else if (cmd.start_set) begin
            start_reg <= idx_reg;
        end
        if (cmd.emit) begin
            if (is_sel && first) begin
                act_reg <= rdata_reg.time_ns;
            end
            out_st_reg   <= cmd.emit_st;
            out_last_reg <= cmd.emit_last;
            out_data_reg <= {resets_reg, peak_reg, bytes_reg[31:0], 6'(count_reg),
                             o_comp, gen_reg, o_act, o_req, o_time, o_handle};
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tuser  = out_st_reg;
    assign m_tlast  = out_last_reg;
    assign m_tdata  = {1'b0, out_data_reg};

endmodule

### sv/kpr_ctrl.sv
// ----------------------------------------------------------------------------
// kpr_ctrl
// Sequencer for push, select and clear over the ring datapath.
// ----------------------------------------------------------------------------
module kpr_ctrl
    import kpr_pkg::*;
(
    input  logic aclk,
    input  logic aresetn,
    input  logic in_accept,
    output logic in_ready,
    input  sts_t sts,
    output cmd_t cmd
);

    localparam logic [4:0] S_IDLE     = 5'd0;
    localparam logic [4:0] S_DECODE   = 5'd1;
    localparam logic [4:0] S_FULLCHK  = 5'd2;
    localparam logic [4:0] S_FULL_EV  = 5'd3;
    localparam logic [4:0] S_APPEND   = 5'd4;
    localparam logic [4:0] S_PT_CHK   = 5'd5;
    localparam logic [4:0] S_PT_RD    = 5'd6;
    localparam logic [4:0] S_PT_EV    = 5'd7;
    localparam logic [4:0] S_PT_END   = 5'd8;
    localparam logic [4:0] S_PK_RD    = 5'd9;
    localparam logic [4:0] S_PK_EV    = 5'd10;
    localparam logic [4:0] S_PO_RD    = 5'd11;
    localparam logic [4:0] S_PO_EV    = 5'd12;
    localparam logic [4:0] S_PB_RD    = 5'd13;
    localparam logic [4:0] S_PB_EV    = 5'd14;
    localparam logic [4:0] S_PN_RD    = 5'd15;
    localparam logic [4:0] S_PN_EV    = 5'd16;
    localparam logic [4:0] S_PUSH_END = 5'd17;
    localparam logic [4:0] S_EMIT_ONE = 5'd18;
    localparam logic [4:0] S_S1_RD    = 5'd19;
    localparam logic [4:0] S_S1_EV    = 5'd20;
    localparam logic [4:0] S_S1_END   = 5'd21;
    localparam logic [4:0] S_S2_RD    = 5'd22;
    localparam logic [4:0] S_S2_EV    = 5'd23;
    localparam logic [4:0] S_S2_END   = 5'd24;
    localparam logic [4:0] S_EM_RD    = 5'd25;
    localparam logic [4:0] S_EM_EV    = 5'd26;

    logic [4:0] state_reg, state_next;
    logic [2:0] st_reg, st_next;

    assign in_ready = state_reg == S_IDLE;

    always_comb begin
        state_next = state_reg;
        st_next    = st_reg;
        cmd        = '0;
        cmd.emit_st = st_reg;
        unique case (state_reg)
            S_IDLE: begin
                if (in_accept) begin
                    cmd.load_in = 1'b1;
                    state_next  = S_DECODE;
                end
            end
            S_DECODE: begin
                unique case (sts.func)
                    FN_PUSH: begin
                        if (sts.invalid) begin
                            st_next    = ST_INVALID;
                            state_next = S_EMIT_ONE;
                        end else if (sts.oversize) begin
                            st_next    = ST_OVERSIZE;
                            state_next = S_EMIT_ONE;
                        end else begin
                            if (sts.gen_chg) begin
                                cmd.ring_reset = 1'b1;
                                st_next        = ST_GEN_RST;
                            end else if (sts.t_regr) begin
                                cmd.ring_reset = 1'b1;
                                st_next        = ST_TIME_RST;
                            end else begin
                                st_next = ST_ACCEPTED;
                            end
                            state_next = S_FULLCHK;
                        end
                    end
                    FN_SELECT: begin
                        cmd.scan_init  = 1'b1;
                        cmd.start_init = 1'b1;
                        cmd.req_load   = 1'b1;
                        state_next     = S_S1_RD;
                    end
                    FN_CLEAR: begin
                        cmd.ring_reset = 1'b1;
                        st_next        = ST_CLEARED;
                        state_next     = S_EMIT_ONE;
                    end
                    default: begin
                        state_next = S_IDLE;
                    end
                endcase
            end
            S_FULLCHK: begin
                if (sts.full) begin
                    cmd.rd_head = 1'b1;
                    state_next  = S_FULL_EV;
                end else begin
                    state_next = S_APPEND;
                end
            end
            S_FULL_EV: begin
                cmd.drop   = 1'b1;
                state_next = S_APPEND;
            end
            S_APPEND: begin
                cmd.append = 1'b1;
                state_next = S_PT_CHK;
            end
            S_PT_CHK: begin
                if (sts.prune_skip) begin
                    state_next = S_PB_RD;
                end else begin
                    cmd.cut_load  = 1'b1;
                    cmd.scan_init = 1'b1;
                    state_next    = S_PT_RD;
                end
            end
            S_PT_RD: begin
                if (sts.idx_lt_cnt) begin
                    cmd.rd_scan = 1'b1;
                    state_next  = S_PT_EV;
                end else begin
                    state_next = S_PT_END;
                end
            end
            S_PT_EV: begin
                if (sts.r_gt_cut) begin
                    state_next = S_PT_END;
                end else begin
                    cmd.keep_set = sts.r_key;
                    cmd.idx_inc  = 1'b1;
                    state_next   = S_PT_RD;
                end
            end
            S_PT_END: begin
                cmd.idx_clr = 1'b1;
                state_next  = sts.found ? S_PK_RD : S_PO_RD;
            end
            S_PK_RD: begin
                if (sts.idx_lt_keep) begin
                    cmd.rd_head = 1'b1;
                    state_next  = S_PK_EV;
                end else begin
                    state_next = S_PB_RD;
                end
            end
            S_PK_EV: begin
                cmd.drop    = 1'b1;
                cmd.idx_inc = 1'b1;
                state_next  = S_PK_RD;
            end
            S_PO_RD: begin
                if (sts.cnt_gt1) begin
                    cmd.rd_head = 1'b1;
                    state_next  = S_PO_EV;
                end else begin
                    state_next = S_PB_RD;
                end
            end
            S_PO_EV: begin
                if (sts.r_lt_cut) begin
                    cmd.drop   = 1'b1;
                    state_next = S_PO_RD;
                end else begin
                    state_next = S_PB_RD;
                end
            end
            S_PB_RD: begin
                if (sts.cnt_nz && sts.bytes_over) begin
                    cmd.rd_head = 1'b1;
                    state_next  = S_PB_EV;
                end else begin
                    state_next = S_PN_RD;
                end
            end
            S_PB_EV: begin
                cmd.drop   = 1'b1;
                state_next = S_PB_RD;
            end
            S_PN_RD: begin
                if (sts.cnt_nz) begin
                    cmd.rd_head = 1'b1;
                    state_next  = S_PN_EV;
                end else begin
                    state_next = S_PUSH_END;
                end
            end
            S_PN_EV: begin
                if (!sts.r_key) begin
                    cmd.drop   = 1'b1;
                    state_next = S_PN_RD;
                end else begin
                    state_next = S_PUSH_END;
                end
            end
            S_PUSH_END: begin
                cmd.peak_upd = 1'b1;
                state_next   = S_EMIT_ONE;
            end
            S_EMIT_ONE: begin
                if (sts.out_free) begin
                    cmd.emit      = 1'b1;
                    cmd.emit_last = 1'b1;
                    state_next    = S_IDLE;
                end
            end
            S_S1_RD: begin
                if (sts.idx_lt_cnt) begin
                    cmd.rd_scan = 1'b1;
                    state_next  = S_S1_EV;
                end else begin
                    state_next = S_S1_END;
                end
            end
            S_S1_EV: begin
                if (sts.r_gt_req) begin
                    state_next = S_S1_END;
                end else begin
                    cmd.start_set = sts.r_key;
                    cmd.idx_inc   = 1'b1;
                    state_next    = S_S1_RD;
                end
            end
            S_S1_END: begin
                cmd.idx_clr = 1'b1;
                state_next  = sts.start_eq_cnt ? S_S2_RD : S_EM_RD;
            end
            S_S2_RD: begin
                if (sts.idx_lt_cnt) begin
                    cmd.rd_scan = 1'b1;
                    state_next  = S_S2_EV;
                end else begin
                    state_next = S_S2_END;
                end
            end
            S_S2_EV: begin
                if (sts.r_gt_trig) begin
                    state_next = S_S2_END;
                end else if (sts.r_key) begin
                    cmd.start_set = 1'b1;
                    state_next    = S_S2_END;
                end else begin
                    cmd.idx_inc = 1'b1;
                    state_next  = S_S2_RD;
                end
            end
            S_S2_END: begin
                cmd.idx_clr = 1'b1;
                if (sts.start_eq_cnt) begin
                    st_next    = ST_NONE;
                    state_next = S_EMIT_ONE;
                end else begin
                    state_next = S_EM_RD;
                end
            end
            S_EM_RD: begin
                cmd.rd_emit = 1'b1;
                state_next  = S_EM_EV;
            end
            S_EM_EV: begin
                cmd.emit_st = ST_SELECTED;
                if (sts.out_free) begin
                    cmd.emit      = 1'b1;
                    cmd.emit_last = sts.em_last;
                    if (sts.em_last) begin
                        state_next = S_IDLE;
                    end else begin
                        cmd.idx_inc = 1'b1;
                        state_next  = S_EM_RD;
                    end
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
            st_reg    <= ST_ACCEPTED;
        end else begin
            state_reg <= state_next;
            st_reg    <= st_next;
        end
    end

endmodule

### sv/keyframe_preroll_ring_core.sv
// ----------------------------------------------------------------------------
// keyframe_preroll_ring_core
// Pre-roll ring of video access-unit descriptors with keyframe-aware pruning.
// ----------------------------------------------------------------------------
// Usage:
//  s_ channel carries one command item: push a unit descriptor, select the
//  pre-roll run, or clear. m_ channel returns results; m_tlast marks the
//  final result of a command, m_tuser holds the status code.
//  Configuration writes (retention time, byte limit) go through the plain
//  cfg_ write port and must only happen while the block is idle.
//  One item is processed at a time; s_tready is high only in the idle state.
//  A push may run the retention walk over the descriptors and then drops pruned
//  ones; a select walks the ring once or twice, then emits the selected
//  descriptors. Both are paced by the single registered read port of the
//  descriptor store.
//  Reset (aresetn low, synchronous) empties the ring, zeroes statistics and
//  loads default configuration. The store itself is not cleared.
//  If the receiver stalls, the held result stays in the output register and
//  the sequencer waits before loading the next one; nothing is lost.
// ----------------------------------------------------------------------------
`include "keyframe_preroll_ring_core_macros.svh"

module keyframe_preroll_ring_core
    import kpr_pkg::*;
#(
    parameter int RING_DEPTH = 32
) (
    input  logic         aclk,
    input  logic         aresetn,
    // configuration
    input  logic         cfg_wr_en,
    input  logic         cfg_index,
    input  logic [63:0]  cfg_wdata,
    // command items
    input  logic         s_tvalid,
    output logic         s_tready,
    // unit_handle, unit_generation, unit_time_ns, unit_bytes, trigger_ns, preroll_ns
    input  logic [279:0] s_tdata,
    // func, unit_keyframe
    input  logic [2:0]   s_tuser,
    // results
    output logic         m_tvalid,
    input  logic         m_tready,
    // sel_handle, sel_time_ns, requested_start_ns, actual_start_ns,
    // ring_generation, preroll_complete, held_units, held_bytes,
    // peak_held_bytes, reset_total, one zero pad bit
    output logic [359:0] m_tdata,
    // status
    output logic [2:0]   m_tuser,
    output logic         m_tlast
);

    in_item_t in_item;
    cmd_t     cmd;
    sts_t     sts;
    logic     in_accept;

    // unpack the command item
    assign in_item.func       = s_tuser[1:0];
    assign in_item.keyframe   = s_tuser[2];
    assign in_item.handle     = s_tdata[31:0];
    assign in_item.generation = s_tdata[63:32];
    assign in_item.time_ns    = s_tdata[127:64];
    assign in_item.bytes      = s_tdata[151:128];
    assign in_item.trigger_ns = s_tdata[215:152];
    assign in_item.preroll_ns = s_tdata[279:216];

    assign in_accept = s_tvalid && s_tready;

    kpr_ctrl u_ctrl (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_accept (in_accept),
        .in_ready  (s_tready),
        .sts       (sts),
        .cmd       (cmd)
    );

    kpr_dp #(
        .RING_DEPTH (RING_DEPTH)
    ) u_dp (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .in_item   (in_item),
        .cmd       (cmd),
        .sts       (sts),
        .m_tready  (m_tready),
        .m_tvalid  (m_tvalid),
        .m_tuser   (m_tuser),
        .m_tlast   (m_tlast),
        .m_tdata   (m_tdata)
    );

    // a taken item keeps the block busy for at least the decode cycle
    `KPR_ASSERT_NEXT(a_busy_after_accept, in_accept, !s_tready,
                     "input accepted while previous item still decoding")

    // push, clear and empty-select results are single items
    `KPR_ASSERT_NOW(a_single_last, m_tvalid && (m_tuser != ST_SELECTED), m_tlast,
                    "non-selection result without last")

    // only selected results carry a unit
    `KPR_ASSERT_NOW(a_sel_zero, m_tvalid && (m_tuser != ST_SELECTED),
                    (m_tdata[95:0] == '0) && (m_tdata[256] == 1'b0),
                    "unit fields set on a non-selection result")

    // occupancy never exceeds the ring depth
    `KPR_ASSERT_NOW(a_depth, m_tvalid, 32'(m_tdata[262:257]) <= 32'(RING_DEPTH),
                    "held unit count beyond ring depth")

endmodule

### test/keyframe_preroll_ring_core_test.sv
// ----------------------------------------------------------------------------
// keyframe_preroll_ring_core_test
// Self-checking bench for the keyframe pre-roll ring. Command items (push,
// select, clear) are fed through the s_ stream and results are collected on
// the m_ stream. A scoreboard predicts every result from its own copy of the
// ring, and each arriving result is compared field by field with the oldest
// prediction. Both sides idle at random. Retention and byte limit are swept
// through several settings, the extremes among them.
// ----------------------------------------------------------------------------
module keyframe_preroll_ring_core_test;
    import kpr_pkg::*;

    localparam int Depth      = 32;
    localparam int ExpDepth   = 64;    // room for one select plus the held result
    localparam int SettleWait = 300;   // worst select walk plus margin
    localparam int StallLimit = 3000;  // cycles with no item moving on either side
    localparam logic [63:0] FramePeriod = 64'd33_333_333;

    typedef struct {
        logic [2:0]  status;
        logic        last;
        logic [31:0] handle;
        logic [63:0] time_ns;
        logic [63:0] req_start;
        logic [63:0] act_start;
        logic [31:0] generation;
        logic        complete;
        logic [5:0]  units;
        logic [31:0] held_bytes;
        logic [31:0] peak_bytes;
        logic [31:0] resets;
    } ring_result_t;

    // ------------------------------------------------------------------------
    // Scoreboard: own copy of the ring, queue of predicted results
    // ------------------------------------------------------------------------
    class ring_scoreboard;
        logic [31:0]  hnd_mem[Depth];
        logic [63:0]  tim_mem[Depth];
        logic [23:0]  len_mem[Depth];
        logic         key_mem[Depth];
        int           head;
        int           count;
        logic [63:0]  total;
        logic [31:0]  gen_cur;
        logic [63:0]  t_latest;
        logic [31:0]  peak;
        logic [31:0]  resets;
        logic [63:0]  retention;
        logic [31:0]  limit;
        ring_result_t exp_buf[ExpDepth];
        int           exp_wr;
        int           exp_rd;
        int           exp_cnt;
        int           fails;

        function new();
            head = 0; count = 0; total = 0; gen_cur = 0; t_latest = 0;
            peak = 0; resets = 0; fails = 0;
            exp_wr = 0; exp_rd = 0; exp_cnt = 0;
            retention = 64'd5_000_000_000;
            limit = 32'd16_777_216;
        endfunction

        function int outstanding();
            return exp_cnt;
        endfunction

        function void set_reg(logic idx, logic [63:0] v);
            if (idx == REG_RETENTION) retention = v;
            else limit = v[31:0];
        endfunction

        function int pos(int i);
            return (head + i) % Depth;
        endfunction

        function void empty_ring();
            count = 0; total = 0; gen_cur = 0; t_latest = 0;
            resets = resets + 32'd1;
        endfunction

        function void drop_oldest();
            if (count == 0) return;
            total = total - 64'(len_mem[head]);
            head = (head + 1) % Depth;
            count--;
            if (count == 0) begin
                gen_cur = 0;
                t_latest = 0;
            end
        endfunction

        function void expire_old();
            logic [63:0] cut;
            int keep;
            bit found;
            keep = 0;
            found = 0;
            if (count < 2 || t_latest <= retention) return;
            cut = t_latest - retention;
            for (int i = 0; i < count; i++) begin
                if (tim_mem[pos(i)] > cut) break;
                if (key_mem[pos(i)]) begin
                    keep = i;
                    found = 1;
                end
            end
            if (!found) begin
                while (count > 1 && tim_mem[pos(0)] < cut) drop_oldest();
            end else begin
                for (int i = 0; i < keep; i++) drop_oldest();
            end
        endfunction

        function void post(logic [2:0] st, logic lst, logic [31:0] h, logic [63:0] t,
                           logic [63:0] rq, logic [63:0] ac, logic cp);
            ring_result_t r;
            r.status = st; r.last = lst; r.handle = h; r.time_ns = t;
            r.req_start = rq; r.act_start = ac; r.complete = cp;
            r.generation = gen_cur; r.units = 6'(count);
            r.held_bytes = total[31:0]; r.peak_bytes = peak; r.resets = resets;
            exp_buf[exp_wr] = r;
            exp_wr = (exp_wr + 1) % ExpDepth;
            exp_cnt++;
        endfunction

        // works out the results of one accepted command item
        function void note_item(in_item_t it);
            logic [2:0]  st;
            logic [63:0] rq, ac;
            int          s, first, n;
            if (it.func == FN_PUSH) begin
                if (it.bytes == 0 || it.generation == 0 || it.time_ns == 0) begin
                    post(ST_INVALID, 1, 0, 0, 0, 0, 0);
                    return;
                end
                if (32'(it.bytes) > limit) begin
                    post(ST_OVERSIZE, 1, 0, 0, 0, 0, 0);
                    return;
                end
                st = ST_ACCEPTED;
                if (count > 0 && it.generation != gen_cur) begin
                    empty_ring();
                    st = ST_GEN_RST;
                end else if (count > 0 && it.time_ns < t_latest) begin
                    empty_ring();
                    st = ST_TIME_RST;
                end
                if (count >= Depth) drop_oldest();
                gen_cur = it.generation;
                t_latest = it.time_ns;
                s = pos(count);
                hnd_mem[s] = it.handle; tim_mem[s] = it.time_ns;
                len_mem[s] = it.bytes; key_mem[s] = it.keyframe;
                count++;
                total = total + 64'(it.bytes);
                expire_old();
                while (count > 0 && total > 64'(limit)) drop_oldest();
                while (count > 0 && !key_mem[pos(0)]) drop_oldest();
                if (total > 64'(peak)) peak = total[31:0];
                post(st, 1, 0, 0, 0, 0, 0);
            end else if (it.func == FN_SELECT) begin
                rq = (it.trigger_ns > it.preroll_ns) ? it.trigger_ns - it.preroll_ns : 0;
                first = count;
                for (int i = 0; i < count; i++) begin
                    if (tim_mem[pos(i)] > rq) break;
                    if (key_mem[pos(i)]) first = i;
                end
                // fallback: earliest keyframe up to the trigger itself
                if (first == count) begin
                    for (int i = 0; i < count; i++) begin
                        if (tim_mem[pos(i)] > it.trigger_ns) break;
                        if (key_mem[pos(i)]) begin
                            first = i;
                            break;
                        end
                    end
                end
                if (first >= count) begin
                    post(ST_NONE, 1, 0, 0, rq, 0, 0);
                    return;
                end
                ac = tim_mem[pos(first)];
                n = count - first;
                if (n > MaxResults) n = MaxResults;
                for (int k = 0; k < n; k++) begin
                    s = pos(first + k);
                    post(ST_SELECTED, k == n - 1, hnd_mem[s], tim_mem[s], rq, ac, ac <= rq);
                end
            end else if (it.func == FN_CLEAR) begin
                empty_ring();
                post(ST_CLEARED, 1, 0, 0, 0, 0, 0);
            end
        endfunction

        task report(string what, logic [63:0] got, logic [63:0] want);
            $display("mismatch %s: got %0h want %0h", what, got, want);
            fails++;
        endtask

        task check_result(ring_result_t g);
            ring_result_t w;
            if (exp_cnt == 0) begin
                report("unexpected result, status", 64'(g.status), 64'd0);
                return;
            end
            w = exp_buf[exp_rd];
            exp_rd = (exp_rd + 1) % ExpDepth;
            exp_cnt--;
            if (g.status !== w.status)
                report("status", 64'(g.status), 64'(w.status));
            if (g.last !== w.last)
                report("last", 64'(g.last), 64'(w.last));
            if (g.handle !== w.handle)
                report("sel_handle", 64'(g.handle), 64'(w.handle));
            if (g.time_ns !== w.time_ns)       report("sel_time", g.time_ns, w.time_ns);
            if (g.req_start !== w.req_start)   report("req_start", g.req_start, w.req_start);
            if (g.act_start !== w.act_start)   report("act_start", g.act_start, w.act_start);
            if (g.generation !== w.generation)
                report("generation", 64'(g.generation), 64'(w.generation));
            if (g.complete !== w.complete)
                report("complete", 64'(g.complete), 64'(w.complete));
            if (g.units !== w.units)
                report("held_units", 64'(g.units), 64'(w.units));
            if (g.held_bytes !== w.held_bytes)
                report("held_bytes", 64'(g.held_bytes), 64'(w.held_bytes));
            if (g.peak_bytes !== w.peak_bytes)
                report("peak_bytes", 64'(g.peak_bytes), 64'(w.peak_bytes));
            if (g.resets !== w.resets)
                report("reset_total", 64'(g.resets), 64'(w.resets));
        endtask
    endclass

    // ------------------------------------------------------------------------
    // Block and its signals
    // ------------------------------------------------------------------------
    logic         aclk = 0;
    logic         aresetn = 0;
    logic         cfg_wr_en = 0;
    logic         cfg_index = REG_RETENTION;
    logic [63:0]  cfg_wdata = '0;
    logic         s_tvalid = 0;
    logic         s_tready;
    // unit_handle, unit_generation, unit_time_ns, unit_bytes, trigger_ns, preroll_ns
    logic [279:0] s_tdata = '0;
    // func, unit_keyframe
    logic [2:0]   s_tuser = '0;
    logic         m_tvalid;
    logic         m_tready = 0;
    // sel_handle, sel_time_ns, requested_start_ns, actual_start_ns, ring_generation,
    // preroll_complete, held_units, held_bytes, peak_held_bytes, reset_total, pad
    logic [359:0] m_tdata;
    // status
    logic [2:0]   m_tuser;
    logic         m_tlast;

    keyframe_preroll_ring_core i_dut (.*);

    always #5 aclk = ~aclk;

    ring_scoreboard sb = new();
    bit             calm = 0;        // no idling on either side while set
    int             idle_cycles = 0;
    int             rx_stall = 0;

    // mostly short gaps, now and then a long one
    function automatic int gap_len();
        int r;
        r = $urandom_range(0, 19);
        if (r < 12) return 0;
        if (r < 18) return $urandom_range(1, 3);
        return $urandom_range(10, 40);
    endfunction

    // ------------------------------------------------------------------------
    // Result side: random stalls, every accepted item checked
    // ------------------------------------------------------------------------
    always @(posedge aclk) begin
        ring_result_t g;
        if (aresetn && m_tvalid && m_tready) begin
            g.handle     = m_tdata[31:0];
            g.time_ns    = m_tdata[95:32];
            g.req_start  = m_tdata[159:96];
            g.act_start  = m_tdata[223:160];
            g.generation = m_tdata[255:224];
            g.complete   = m_tdata[256];
            g.units      = m_tdata[262:257];
            g.held_bytes = m_tdata[294:263];
            g.peak_bytes = m_tdata[326:295];
            g.resets     = m_tdata[358:327];
            g.status     = m_tuser;
            g.last       = m_tlast;
            sb.check_result(g);
        end
        if (calm || !aresetn) begin
            m_tready <= aresetn;
            rx_stall <= 0;
        end else if (rx_stall > 0) begin
            m_tready <= 0;
            rx_stall <= rx_stall - 1;
        end else begin
            rx_stall <= gap_len();
            m_tready <= 1;
        end
    end

    // watchdog: no item moving on either side for too long
    always @(posedge aclk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) idle_cycles <= 0;
        else idle_cycles <= idle_cycles + 1;
        if (idle_cycles == StallLimit) begin
            $display("tb: failure");
            $finish;
        end
    end

    // ------------------------------------------------------------------------
    // Command side
    // ------------------------------------------------------------------------
    task automatic send(in_item_t it);
        int g;
        g = gap_len();
        if (g > 0 && !calm) begin
            s_tvalid <= 0;
            repeat (g) @(posedge aclk);
        end
        s_tdata  <= {it.preroll_ns, it.trigger_ns, it.bytes, it.time_ns,
                     it.generation, it.handle};
        s_tuser  <= {it.keyframe, it.func};
        s_tvalid <= 1;
        do @(posedge aclk); while (!s_tready);
        sb.note_item(it);
    endtask

    // all results in, then let a result-less item finish too
    task automatic settle();
        s_tvalid <= 0;
        while (sb.outstanding() != 0) @(posedge aclk);
        repeat (SettleWait) @(posedge aclk);
    endtask

    task automatic write_reg(logic idx, logic [63:0] v);
        settle();
        cfg_wr_en <= 1;
        cfg_index <= idx;
        cfg_wdata <= v;
        @(posedge aclk);
        cfg_wr_en <= 0;
        sb.set_reg(idx, v);
    endtask

    function automatic logic [63:0] rnd64();
        return {$urandom, $urandom};
    endfunction

    function automatic in_item_t mk(logic [1:0] f, logic [31:0] g, logic [63:0] t,
                                    logic [23:0] b, logic k, logic [63:0] trg,
                                    logic [63:0] pre);
        in_item_t it;
        it.func = f; it.handle = $urandom; it.generation = g; it.time_ns = t;
        it.bytes = b; it.keyframe = k; it.trigger_ns = trg; it.preroll_ns = pre;
        return it;
    endfunction

    logic [63:0] t_now = 64'd1_000_000_000;
    logic [31:0] gen_now = 32'd1;

    // one random item; returns 0 for the ignored func code
    task automatic random_item(output bit counted);
        int          r;
        logic [23:0] b;
        in_item_t    it;
        r = $urandom_range(0, 99);
        b = 24'($urandom_range(1, 60000));
        t_now = t_now + FramePeriod + 64'($urandom_range(0, 2_000_000));
        counted = 1;
        if (r < 60) begin
            it = mk(FN_PUSH, gen_now, t_now, b, $urandom_range(0, 5) == 0, rnd64(), rnd64());
        end else if (r < 66) begin
            it = mk(FN_PUSH, gen_now, t_now, b + 24'd150000, 1, rnd64(), rnd64());
        end else if (r < 70) begin
            gen_now = $urandom;
            if (gen_now == 0) gen_now = 1;
            if ($urandom_range(0, 3) == 0) t_now = (rnd64() >> 1) | 64'd1;
            it = mk(FN_PUSH, gen_now, t_now, b, 1'($urandom_range(0, 1)), rnd64(), rnd64());
        end else if (r < 73) begin
            // timestamp regression
            if (t_now > 64'd2_000_000_000) t_now = t_now - 64'd1_500_000_000;
            it = mk(FN_PUSH, gen_now, t_now, b, 1, rnd64(), rnd64());
        end else if (r < 76) begin
            it = mk(FN_PUSH, gen_now, t_now, b, 1, rnd64(), rnd64());
            case ($urandom_range(0, 2))
                0: it.bytes = 0;
                1: it.generation = 0;
                default: it.time_ns = 0;
            endcase
        end else if (r < 79) begin
            it = mk(FN_PUSH, gen_now, t_now, 24'($urandom), 1, rnd64(), rnd64());
        end else if (r < 90) begin
            it = mk(FN_SELECT, $urandom, rnd64(), 24'($urandom), 1'($urandom),
                    t_now - 64'($urandom_range(0, 300_000_000)),
                    64'($urandom_range(0, 32'hFFFF_FFFF)));
        end else if (r < 94) begin
            it = mk(FN_SELECT, $urandom, rnd64(), 24'($urandom), 1'($urandom),
                    rnd64(), rnd64());
        end else if (r < 96) begin
            it = mk(FN_CLEAR, $urandom, rnd64(), 24'($urandom), 1'($urandom),
                    rnd64(), rnd64());
        end else if (r < 98) begin
            it = mk(2'd3, $urandom, rnd64(), 24'($urandom), 1'($urandom), rnd64(), rnd64());
            counted = 0;
        end else begin
            it = mk(FN_PUSH, $urandom, rnd64(), 24'($urandom), 1'($urandom),
                    rnd64(), rnd64());
        end
        send(it);
    endtask

    logic [63:0] ret_set[6] = '{64'd5_000_000_000, 64'd200_000_000, 64'd1,
                                64'hFFFF_FFFF_FFFF_FFFF, 64'd100_000_000,
                                64'd5_000_000_000};
    logic [63:0] lim_set[6] = '{64'd16_777_216, 64'd600_000, 64'hFFFF_FFFF,
                                64'd1, 64'd250_000, 64'd16_777_216};

    initial begin
        bit counted;
        int n;
        repeat (9) @(posedge aclk);
        aresetn <= 1;
        @(posedge aclk);

        // directed part, default configuration
        send(mk(FN_SELECT, 1, 1, 1, 0, 64'd100, 64'd0));            // empty ring
        send(mk(FN_CLEAR, 1, 1, 1, 0, 0, 0));
        send(mk(FN_PUSH, 1, 64'd5, 0, 1, 0, 0));                     // zero size
        send(mk(FN_PUSH, 0, 64'd5, 24'd10, 1, 0, 0));                // zero generation
        send(mk(FN_PUSH, 1, 64'd0, 24'd10, 1, 0, 0));                // zero time
        send(mk(FN_PUSH, 1, 64'd1, 24'hFF_FFFF, 1, 0, 0));           // largest unit
        send(mk(FN_PUSH, 1, 64'd2, 24'd100, 0, 0, 0));
        send(mk(FN_PUSH, 1, 64'd3, 24'd100, 1, 0, 0));               // keyframe into the ring emptied by the byte prune
        send(mk(FN_PUSH, 1, 64'd4, 24'd100, 0, 0, 0));
        send(mk(FN_SELECT, 0, 0, 0, 0, 64'hFFFF_FFFF_FFFF_FFFF, 64'd0));
        send(mk(FN_SELECT, 0, 0, 0, 0, 64'd0, 64'hFFFF_FFFF_FFFF_FFFF));
        send(mk(FN_SELECT, 0, 0, 0, 0, 64'd4, 64'd2));
        send(mk(FN_PUSH, 32'hFFFF_FFFF, 64'd10, 24'd1, 0, 0, 0));    // generation change
        send(mk(FN_PUSH, 32'hFFFF_FFFF, 64'd9, 24'd1, 1, 0, 0));     // earlier time into an empty ring
        send(mk(FN_PUSH, 32'hFFFF_FFFF, 64'hFFFF_FFFF_FFFF_FFFF, 24'd1, 1, 0, 0));
        send(mk(FN_SELECT, 0, 0, 0, 0, 64'd5, 64'd1));               // fallback walk, no start found
        send(mk(2'd3, 0, 0, 0, 0, 0, 0));                            // ignored func
        for (int i = 0; i < 5; i++)
            send(mk(FN_PUSH, 7, 64'd1000 + i, 24'd50, i == 0, 0, 0));
        send(mk(FN_SELECT, 0, 0, 0, 0, 64'd2000, 64'd0));

        // random phases across the register settings
        for (int p = 0; p < 6; p++) begin
            write_reg(REG_RETENTION, ret_set[p]);
            write_reg(REG_BYTE_LIMIT, lim_set[p]);
            n = 0;
            while (n < 80) begin
                if (n % 20 == 0) calm = $urandom_range(0, 3) == 0;
                // hold the sender until the ring has answered everything
                if (p == 1 && n == 40) begin
                    s_tvalid <= 0;
                    do @(posedge aclk); while (sb.outstanding() != 0);
                end
                random_item(counted);
                if (counted) n++;
            end
        end

        calm = 0;
        settle();
        if (sb.fails == 0) begin
            $display("tb: success");
        end else begin
            $display("tb: failure");
        end
        $finish;
    end

endmodule
